// File: hw/rtl/hdh_pkg.sv
// ----------------------------------------------------------------------------
// hdh_pkg
// Shared widths, register indexes, reset values and types for the hook
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hdh_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int DEB_BITS    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;
  typedef logic [DEB_BITS-1:0]    deb_t;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFF = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = CFG_IDX_W'(2);

  localparam sample_t RST_THRESHOLD_ON  = SAMPLE_BITS'(2000);
  localparam sample_t RST_THRESHOLD_OFF = SAMPLE_BITS'(1000);
  localparam deb_t    RST_DEBOUNCE_MS   = DEB_BITS'(50);

  // comparator verdict for one sample
  typedef struct packed {
    logic reading;
    logic line_break;
  } class_t;

  // debounced hook status
  typedef struct packed {
    logic handset_up;
    logic hook_changed;
  } hook_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/hdh_classify.sv
// ----------------------------------------------------------------------------
// hdh_classify
// Hysteresis comparator: clamps the off threshold and classifies a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module hdh_classify (
  input  wire hdh_pkg::sample_t sample,
  input  wire hdh_pkg::sample_t threshold_on,
  input  wire hdh_pkg::sample_t threshold_off,
  input  wire logic             committed_handset_up,
  output hdh_pkg::class_t       verdict
);
  import hdh_pkg::*;

  sample_t eff_off;

  always_comb begin
    if (threshold_on == '0) begin
      eff_off = '0;
    end else if (threshold_off >= threshold_on) begin
      eff_off = threshold_on - SAMPLE_BITS'(1);
    end else begin
      eff_off = threshold_off;
    end
  end

  always_comb begin
    verdict.reading    = (sample >= threshold_on) ||
                         (committed_handset_up && (sample > eff_off));
    verdict.line_break = sample < eff_off;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hdh_debounce.sv
// ----------------------------------------------------------------------------
// hdh_debounce
// Pending/committed hook state with timestamp-based hold timer.
// ----------------------------------------------------------------------------
`default_nettype none

module hdh_debounce (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             reading,
  input  wire hdh_pkg::stamp_t  now,
  input  wire hdh_pkg::deb_t    debounce_ms,
  output logic                  committed_handset_up,
  output hdh_pkg::hook_res_t    result
);
  import hdh_pkg::*;

  logic   committed_r, committed_nxt;
  logic   pending_r, pending_nxt;
  stamp_t stamp_r, stamp_nxt;
  stamp_t elapsed;
  logic   changed;

  // difference wraps modulo 2^32
  assign elapsed = now - stamp_r;

  always_comb begin
    committed_nxt = committed_r;
    pending_nxt   = pending_r;
    stamp_nxt     = stamp_r;
    changed       = 1'b0;
    if (reading != pending_r) begin
      pending_nxt = reading;
      stamp_nxt   = now;
    end else if ((pending_r != committed_r) && (elapsed >= TIME_BITS'(debounce_ms))) begin
      committed_nxt = pending_r;
      changed       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= 1'b0;
      pending_r   <= 1'b0;
      stamp_r     <= '0;
    end else if (advance) begin
      committed_r <= committed_nxt;
      pending_r   <= pending_nxt;
      stamp_r     <= stamp_nxt;
    end
  end

  assign committed_handset_up = committed_r;
  assign result.handset_up    = committed_nxt;
  assign result.hook_changed  = changed;

endmodule

`default_nettype wire

// File: hw/rtl/hook_detect_hysteresis_debounce.sv
// ----------------------------------------------------------------------------
// hook_detect_hysteresis_debounce
// Line-sense hook detector: hysteresis comparator followed by a debounce
// timer; one result per sample.
// ----------------------------------------------------------------------------
// pipeline: result is registered (input register, then result register);
//   throughput: one request per cycle unless out_stall holds the output, set
//   by the combinational compare and 32-bit subtract between the two registers
// reset: synchronous active-low; clears state to on-hook, stamp 0, and loads
//   thresholds 2000/1000 and debounce 50 ms
`default_nettype none

module hook_detect_hysteresis_debounce (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [hdh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hdh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [hdh_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  wire logic [hdh_pkg::TIME_BITS-1:0]    in_time_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_handset_up,
  output logic                                  out_hook_changed,
  output logic                                  out_line_break
);
  import hdh_pkg::*;

  sample_t   threshold_on_r, threshold_off_r;
  deb_t      debounce_ms_r;

  logic      s1_valid_r;
  sample_t   s1_sample_r;
  stamp_t    s1_time_r;

  logic      out_valid_r;
  logic      out_handset_up_r, out_hook_changed_r, out_line_break_r;

  logic      out_free;
  logic      advance;
  logic      committed;
  class_t    verdict;
  hook_res_t hook_res;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_on_r  <= RST_THRESHOLD_ON;
      threshold_off_r <= RST_THRESHOLD_OFF;
      debounce_ms_r   <= RST_DEBOUNCE_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD_ON:  threshold_on_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_THRESHOLD_OFF: threshold_off_r <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DEBOUNCE_MS:   debounce_ms_r   <= cfg_wdata[DEB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_sample_r <= in_sample;
      s1_time_r   <= in_time_ms;
    end
  end

  hdh_classify u_classify (
    .sample               (s1_sample_r),
    .threshold_on         (threshold_on_r),
    .threshold_off        (threshold_off_r),
    .committed_handset_up (committed),
    .verdict              (verdict)
  );

  hdh_debounce u_debounce (
    .clk                  (clk),
    .rst_n                (rst_n),
    .advance              (advance),
    .reading              (verdict.reading),
    .now                  (s1_time_r),
    .debounce_ms          (debounce_ms_r),
    .committed_handset_up (committed),
    .result               (hook_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_handset_up_r   <= hook_res.handset_up;
      out_hook_changed_r <= hook_res.hook_changed;
      out_line_break_r   <= verdict.line_break;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_handset_up   = out_handset_up_r;
  assign out_hook_changed = out_hook_changed_r;
  assign out_line_break   = out_line_break_r;

endmodule

`default_nettype wire
